// ----- src/keypad_calculator_stopwatch_macros.svh -----
// Assertion macros for the keypad calculator and stopwatch.
// Each macro expects a clock named i_clk and an active-low reset i_rst_n in scope.
`ifndef KEYPAD_CALCULATOR_STOPWATCH_MACROS_SVH
`define KEYPAD_CALCULATOR_STOPWATCH_MACROS_SVH

// Same-cycle implication, checked out of reset
`define KCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define KCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/kcs_pkg.sv -----
// Shared types and constants for the keypad calculator and stopwatch.
// No dependencies; used by kcs_calc, kcs_timer and the top level.
package kcs_pkg;

    // Key codes
    localparam logic [3:0] CODE_DIGIT_MAX = 4'd9;
    localparam logic [3:0] CODE_CLEAR     = 4'd10;
    localparam logic [3:0] CODE_MODE      = 4'd11;
    localparam logic [3:0] CODE_PLUS      = 4'd12;
    localparam logic [3:0] CODE_MINUS     = 4'd13;
    localparam logic [3:0] CODE_MUL       = 4'd14;
    localparam logic [3:0] CODE_ENTER     = 4'd15;

    // Stopwatch limits
    localparam logic [6:0] HUND_LAST = 7'd99;
    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [5:0] MIN_LAST  = 6'd59;

    // Output word layout
    localparam int unsigned OUT_BITS  = 123;
    localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_RESULT = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2,
        OP_MUL  = 2'd3
    } t_op;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] acc;
        logic [31:0] second;
        t_op         op;
        logic [31:0] shown;
        logic        overflow;
    } t_calc;

    typedef struct packed {
        logic       run;
        logic [5:0] mins;
        logic [5:0] secs;
        logic [6:0] hund;
    } t_timer;

endpackage

// ----- src/kcs_calc.sv -----
// Calculator next-state logic: digit entry, operator select and evaluation.
// Depends on kcs_pkg.
module kcs_calc (
    input  kcs_pkg::t_calc i_state,
    input  logic           i_en,
    input  logic [3:0]     i_key,
    output kcs_pkg::t_calc o_next
);
    import kcs_pkg::*;

    localparam logic signed [31:0] DIGIT_LIMIT = 32'sd100000000;

    logic               w_digit;
    logic               w_oper;
    t_op                w_key_op;
    logic signed [31:0] w_a;
    logic signed [31:0] w_b;
    logic signed [63:0] w_res;
    logic               w_ovf;

    // Append one decimal digit while the operand stays under the limit
    function automatic logic [31:0] append_digit(input logic [31:0] v, input logic [3:0] d);
        logic [31:0] r;
        begin
            r = v;
            if ($signed(v) < DIGIT_LIMIT) begin
                r = (v << 3) + (v << 1) + {28'd0, d};
            end
            return r;
        end
    endfunction

    assign w_digit = i_key <= CODE_DIGIT_MAX;
    assign w_oper  = i_key inside {CODE_PLUS, CODE_MINUS, CODE_MUL};

    // Map operator key to operator code
    always_comb begin
        case (i_key)
            CODE_PLUS:  w_key_op = OP_ADD;
            CODE_MINUS: w_key_op = OP_SUB;
            CODE_MUL:   w_key_op = OP_MUL;
            default:    w_key_op = OP_NONE;
        endcase
    end

    // Evaluate the pending operation at full width and range-check it
    assign w_a = $signed(i_state.acc);
    assign w_b = $signed(i_state.second);

    always_comb begin
        case (i_state.op)
            OP_ADD:  w_res = 64'(w_a) + 64'(w_b);
            OP_SUB:  w_res = 64'(w_a) - 64'(w_b);
            OP_MUL:  w_res = 64'(w_a) * 64'(w_b);
            default: w_res = '0;
        endcase
    end

    assign w_ovf = !((&w_res[63:31]) || !(|w_res[63:31]));

    // Step the calculator for one key
    always_comb begin
        o_next = i_state;
        if (i_en) begin
            case (i_state.phase)
                PH_FIRST: begin
                    if (w_digit) begin
                        o_next.acc = append_digit(i_state.acc, i_key);
                    end else if (w_oper) begin
                        o_next.op    = w_key_op;
                        o_next.phase = PH_SECOND;
                    end else if (i_key == CODE_CLEAR) begin
                        o_next.acc = '0;
                    end
                end
                PH_SECOND: begin
                    if (w_digit) begin
                        o_next.second = append_digit(i_state.second, i_key);
                    end else if (i_key == CODE_ENTER) begin
                        o_next.shown    = i_state.acc;
                        o_next.overflow = w_ovf;
                        o_next.acc      = w_ovf ? 32'd0 : w_res[31:0];
                        o_next.phase    = PH_RESULT;
                    end else if (i_key == CODE_CLEAR) begin
                        o_next.acc    = '0;
                        o_next.second = '0;
                        o_next.op     = OP_NONE;
                        o_next.phase  = PH_FIRST;
                    end
                end
                PH_RESULT: begin
                    if (w_digit) begin
                        o_next.acc    = {28'd0, i_key};
                        o_next.second = '0;
                        o_next.op     = OP_NONE;
                        o_next.phase  = PH_FIRST;
                    end else if (w_oper) begin
                        o_next.op     = w_key_op;
                        o_next.second = '0;
                        o_next.phase  = PH_SECOND;
                    end else if (i_key == CODE_CLEAR) begin
                        o_next.acc    = '0;
                        o_next.second = '0;
                        o_next.op     = OP_NONE;
                        o_next.phase  = PH_FIRST;
                    end
                end
                default: begin
                    o_next = i_state;
                end
            endcase
        end
    end

endmodule

// ----- src/kcs_timer.sv -----
// Stopwatch next-state logic: tick counting, start/stop, reset and beep.
// Depends on kcs_pkg.
module kcs_timer (
    input  kcs_pkg::t_timer i_state,
    input  logic            i_tick,
    input  logic            i_key_en,
    input  logic [3:0]      i_key,
    input  logic            i_stop,
    input  logic            i_mode,
    output kcs_pkg::t_timer o_next,
    output logic            o_beep
);
    import kcs_pkg::*;

    always_comb begin
        o_next = i_state;
        o_beep = 1'b0;
        if (i_tick) begin
            // Advance hundredths, carry into seconds and minutes
            if (i_state.run) begin
                if (i_state.hund >= HUND_LAST) begin
                    o_next.hund = '0;
                    if (i_state.secs >= SEC_LAST) begin
                        o_next.secs = '0;
                        o_next.mins = (i_state.mins >= MIN_LAST) ? 6'd0 : i_state.mins + 6'd1;
                    end else begin
                        o_next.secs = i_state.secs + 6'd1;
                    end
                    o_beep = i_mode && (o_next.secs inside {6'd10, 6'd20, 6'd30, 6'd40, 6'd50});
                end else begin
                    o_next.hund = i_state.hund + 7'd1;
                end
            end
        end else if (i_stop) begin
            // Mode change always halts the stopwatch
            o_next.run = 1'b0;
        end else if (i_key_en) begin
            if (i_key == CODE_ENTER) begin
                o_beep     = !i_state.run;
                o_next.run = !i_state.run;
            end else if (i_key == CODE_CLEAR) begin
                o_next = '0;
            end
        end
    end

endmodule

// ----- src/keypad_calculator_stopwatch.sv -----
// Keypad calculator and stopwatch. Every input word is a key press or a 10 ms tick
// (tuser bit 0 set) and produces exactly one output word carrying the full state
// after that item plus a beep flag. One word is accepted every clock cycle while the output
// is not stalled; the result word passes through the input register and then the state
// register that doubles as the output register. A stalled output holds both stages.
// Throughput is limited by the state feedback, whose longest path is the 32x32 signed
// multiply and range check taken on ENTER. Ticks count only while the stopwatch runs,
// which happens only in timer mode, since a mode change halts it.
// Depends on kcs_pkg, kcs_calc, kcs_timer and keypad_calculator_stopwatch_macros.svh.
`include "keypad_calculator_stopwatch_macros.svh"

module keypad_calculator_stopwatch (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,   // [3:0] key_code
    input  logic [0:0]                          i_s_tuser,   // [0] opcode (1 = tick)
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [0] timer_mode, [2:1] calc_phase, [34:3] accumulator, [66:35] second_operand,
    // [68:67] operator_code, [100:69] shown_first_operand, [101] overflow,
    // [107:102] minutes, [113:108] seconds, [120:114] hundredths, [121] running,
    // [122] beep
    output logic [kcs_pkg::OUT_BYTES*8-1:0]     o_m_tdata
);
    import kcs_pkg::*;

    logic       r_in_valid;
    logic       r_op;
    logic [3:0] r_key;
    logic       r_out_valid;
    logic       r_mode;
    t_calc      r_calc;
    t_timer     r_timer;
    logic       r_beep;

    logic       n_mode;
    t_calc      n_calc;
    t_timer     n_timer;
    logic       n_beep;
    logic       w_out_free;
    logic       w_proc;
    logic       w_key;
    logic       w_mode_key;

    // Handshake: the input stage frees up as soon as its word moves on
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_proc     = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;

    // Decode the held word
    assign w_key      = w_proc && !r_op;
    assign w_mode_key = w_key && (r_key == CODE_MODE);
    assign n_mode     = r_mode ^ w_mode_key;

    kcs_calc u_calc (
        .i_state (r_calc),
        .i_en    (w_key && !w_mode_key && !r_mode),
        .i_key   (r_key),
        .o_next  (n_calc)
    );

    kcs_timer u_timer (
        .i_state  (r_timer),
        .i_tick   (w_proc && r_op),
        .i_key_en (w_key && !w_mode_key && r_mode),
        .i_key    (r_key),
        .i_stop   (w_mode_key),
        .i_mode   (r_mode),
        .o_next   (n_timer),
        .o_beep   (n_beep)
    );

    // Input register: hold the word until the state stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_op  <= i_s_tuser[0];
            r_key <= i_s_tdata[3:0];
        end
    end

    // State and output register: advance once per processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_mode      <= 1'b0;
            r_calc      <= '0;
            r_timer     <= '0;
            r_beep      <= 1'b0;
        end else begin
            r_out_valid <= w_proc || (r_out_valid && !i_m_tready);
            if (w_proc) begin
                r_mode  <= n_mode;
                r_calc  <= n_calc;
                r_timer <= n_timer;
                r_beep  <= n_beep;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_BYTES*8-OUT_BITS){1'b0}},
                         r_beep, r_timer.run, r_timer.hund, r_timer.secs, r_timer.mins,
                         r_calc.overflow, r_calc.shown, r_calc.op, r_calc.second,
                         r_calc.acc, r_calc.phase, r_mode};

    // Checks
    `KCS_ASSERT_NOW(a_time_range, 1'b1,
        r_timer.hund <= HUND_LAST && r_timer.secs <= SEC_LAST && r_timer.mins <= MIN_LAST,
        "stopwatch count out of range")
    `KCS_ASSERT_NOW(a_run_in_timer, r_timer.run, r_mode,
        "stopwatch running in calculator mode")
    `KCS_ASSERT_NEXT(a_state_hold, !w_proc,
        $stable(r_calc) && $stable(r_timer) && $stable(r_mode) && $stable(r_beep),
        "state changed without a processed word")
    `KCS_ASSERT_NEXT(a_in_hold, r_in_valid && !w_out_free,
        r_in_valid && $stable(r_key) && $stable(r_op),
        "held input word lost or changed")
    `KCS_ASSERT_NOW(a_no_phase3, 1'b1, r_calc.phase <= PH_RESULT,
        "calculator reached unused phase")

endmodule

// ----- dv/kcs_stream_checker.sv -----
// Scoreboard for the keypad calculator and stopwatch: watches both stream channels,
// predicts the state word that each accepted input word must produce, and compares.
// Depends on kcs_pkg for key codes, stopwatch limits, phase and operator types.
module kcs_stream_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_tvalid,
    input  logic                                i_in_tready,
    input  logic [7:0]                          i_in_tdata,   // [3:0] key_code
    input  logic [0:0]                          i_in_tuser,   // [0] opcode (1 = tick)
    input  logic                                i_out_tvalid,
    input  logic                                i_out_tready,
    // [0] timer_mode, [2:1] calc_phase, [34:3] accumulator, [66:35] second_operand,
    // [68:67] operator_code, [100:69] shown_first_operand, [101] overflow,
    // [107:102] minutes, [113:108] seconds, [120:114] hundredths, [121] running,
    // [122] beep
    input  logic [kcs_pkg::OUT_BYTES*8-1:0]     i_out_tdata,
    output int unsigned                         o_fail_count,
    output int unsigned                         o_pending,
    output int unsigned                         o_words_checked,
    output int unsigned                         o_overflows_seen,
    output int unsigned                         o_beeps_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import kcs_pkg::*;

    localparam int    OPERAND_LIMIT = 100000000;
    localparam longint RESULT_MAX   = 64'sd2147483647;
    localparam longint RESULT_MIN   = -64'sd2147483648;

    typedef struct {
        bit          timer_mode;
        t_phase      phase;
        logic [31:0] acc;
        logic [31:0] second;
        t_op         op;
        logic [31:0] shown;
        bit          overflow;
        logic [5:0]  mins;
        logic [5:0]  secs;
        logic [6:0]  hund;
        bit          running;
        bit          beep;
    } t_kcs_view;

    // Mirror of the block's state
    bit          timer_mode_q;
    t_phase      calc_phase;
    logic [31:0] acc_q;
    logic [31:0] second_q;
    t_op         op_sel;
    logic [31:0] shown_q;
    bit          overflow_q;
    logic [5:0]  sw_mins;
    logic [5:0]  sw_secs;
    logic [6:0]  sw_hund;
    bit          sw_running;

    // Display states still owed by the block, oldest first
    t_kcs_view   owed_views[$];

    // Append a decimal digit unless the operand has reached the entry limit
    function automatic logic [31:0] with_digit(logic [31:0] operand, logic [3:0] digit);
        if ($signed(operand) < OPERAND_LIMIT)
            return operand * 32'd10 + {28'd0, digit};
        return operand;
    endfunction

    function automatic t_op op_for_key(logic [3:0] key);
        case (key)
            CODE_PLUS:  return OP_ADD;
            CODE_MINUS: return OP_SUB;
            default:    return OP_MUL;
        endcase
    endfunction

    task automatic clear_operands();
        acc_q      = '0;
        second_q   = '0;
        op_sel     = OP_NONE;
        calc_phase = PH_FIRST;
    endtask

    task automatic reset_state();
        timer_mode_q = 1'b0;
        clear_operands();
        shown_q      = '0;
        overflow_q   = 1'b0;
        sw_mins      = '0;
        sw_secs      = '0;
        sw_hund      = '0;
        sw_running   = 1'b0;
    endtask

    // Advance the mirror by one key press or tick and return the display state after it
    task automatic apply_word(input bit is_tick, input logic [3:0] key, output t_kcs_view v);
        bit     beep_now;
        bit     is_digit;
        bit     is_oper;
        longint lhs;
        longint rhs;
        longint res;
        beep_now = 1'b0;
        is_digit = key <= CODE_DIGIT_MAX;
        is_oper  = key >= CODE_PLUS && key <= CODE_MUL;
        if (is_tick) begin
            // count only while running; beep on each tenth second in timer mode
            if (sw_running) begin
                if (sw_hund == HUND_LAST) begin
                    sw_hund = '0;
                    if (sw_secs == SEC_LAST) begin
                        sw_secs = '0;
                        sw_mins = (sw_mins == MIN_LAST) ? 6'd0 : sw_mins + 6'd1;
                    end else begin
                        sw_secs = sw_secs + 6'd1;
                    end
                    beep_now = timer_mode_q && sw_secs != 0 && sw_secs % 10 == 0;
                end else begin
                    sw_hund = sw_hund + 7'd1;
                end
            end
        end else if (key == CODE_MODE) begin
            timer_mode_q = !timer_mode_q;
            sw_running   = 1'b0;
        end else if (!timer_mode_q) begin
            case (calc_phase)
                PH_FIRST: begin
                    if (is_digit) begin
                        acc_q = with_digit(acc_q, key);
                    end else if (is_oper) begin
                        op_sel     = op_for_key(key);
                        calc_phase = PH_SECOND;
                    end else if (key == CODE_CLEAR) begin
                        acc_q = '0;
                    end
                end
                PH_SECOND: begin
                    if (is_digit) begin
                        second_q = with_digit(second_q, key);
                    end else if (key == CODE_ENTER) begin
                        // evaluate in 64 bits, zero the result when it leaves 32-bit range
                        shown_q = acc_q;
                        lhs = $signed(acc_q);
                        rhs = $signed(second_q);
                        case (op_sel)
                            OP_ADD:  res = lhs + rhs;
                            OP_SUB:  res = lhs - rhs;
                            OP_MUL:  res = lhs * rhs;
                            default: res = 0;
                        endcase
                        if (res > RESULT_MAX || res < RESULT_MIN) begin
                            overflow_q = 1'b1;
                            acc_q      = '0;
                            o_overflows_seen++;
                        end else begin
                            overflow_q = 1'b0;
                            acc_q      = res[31:0];
                        end
                        calc_phase = PH_RESULT;
                    end else if (key == CODE_CLEAR) begin
                        clear_operands();
                    end
                end
                PH_RESULT: begin
                    if (is_digit) begin
                        acc_q      = {28'd0, key};
                        second_q   = '0;
                        op_sel     = OP_NONE;
                        calc_phase = PH_FIRST;
                    end else if (is_oper) begin
                        op_sel     = op_for_key(key);
                        second_q   = '0;
                        calc_phase = PH_SECOND;
                    end else if (key == CODE_CLEAR) begin
                        clear_operands();
                    end
                end
                default: ;
            endcase
        end else if (key == CODE_ENTER) begin
            if (!sw_running)
                beep_now = 1'b1;
            sw_running = !sw_running;
        end else if (key == CODE_CLEAR) begin
            sw_running = 1'b0;
            sw_mins    = '0;
            sw_secs    = '0;
            sw_hund    = '0;
        end

        v.timer_mode = timer_mode_q;
        v.phase      = calc_phase;
        v.acc        = acc_q;
        v.second     = second_q;
        v.op         = op_sel;
        v.shown      = shown_q;
        v.overflow   = overflow_q;
        v.mins       = sw_mins;
        v.secs       = sw_secs;
        v.hund       = sw_hund;
        v.running    = sw_running;
        v.beep       = beep_now;
    endtask

    function automatic t_kcs_view unpack_view(logic [OUT_BYTES*8-1:0] w);
        t_kcs_view v;
        v.timer_mode = w[0];
        v.phase      = t_phase'(w[2:1]);
        v.acc        = w[34:3];
        v.second     = w[66:35];
        v.op         = t_op'(w[68:67]);
        v.shown      = w[100:69];
        v.overflow   = w[101];
        v.mins       = w[107:102];
        v.secs       = w[113:108];
        v.hund       = w[120:114];
        v.running    = w[121];
        v.beep       = w[122];
        return v;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            o_fail_count++;
        end
    endtask

    // Retire the oldest owed state on each output word, then queue the next prediction
    always @(posedge i_clk) begin : watch
        t_kcs_view want;
        t_kcs_view got;
        if (!i_rst_n) begin
            reset_state();
            owed_views.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                if (owed_views.size() == 0) begin
                    $error("output word 0x%0h arrived with nothing owed", i_out_tdata);
                    o_fail_count++;
                end else begin
                    want = owed_views.pop_front();
                    got  = unpack_view(i_out_tdata);
                    compare_field("timer_mode", 32'(want.timer_mode), 32'(got.timer_mode));
                    compare_field("calc_phase", 32'(want.phase), 32'(got.phase));
                    compare_field("accumulator", want.acc, got.acc);
                    compare_field("second_operand", want.second, got.second);
                    compare_field("operator_code", 32'(want.op), 32'(got.op));
                    compare_field("shown_first_operand", want.shown, got.shown);
                    compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
                    compare_field("minutes", 32'(want.mins), 32'(got.mins));
                    compare_field("seconds", 32'(want.secs), 32'(got.secs));
                    compare_field("hundredths", 32'(want.hund), 32'(got.hund));
                    compare_field("running", 32'(want.running), 32'(got.running));
                    compare_field("beep", 32'(want.beep), 32'(got.beep));
                    if (i_out_tdata[OUT_BYTES*8-1:OUT_BITS] !== '0) begin
                        $error("padding: expected 0x0, got 0x%0h",
                               i_out_tdata[OUT_BYTES*8-1:OUT_BITS]);
                        o_fail_count++;
                    end
                    o_words_checked++;
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                apply_word(i_in_tuser[0], i_in_tdata[3:0], want);
                if (want.beep)
                    o_beeps_seen++;
                owed_views.push_back(want);
            end
        end
        o_pending = owed_views.size();
    end

endmodule

// ----- dv/tb_keypad_calculator_stopwatch.sv -----
// Testbench top for the keypad calculator and stopwatch: clock, reset, key and tick
// stimulus with random idling on both channels, watchdog and verdict.
// Depends on kcs_pkg, keypad_calculator_stopwatch and kcs_stream_checker.
module tb_keypad_calculator_stopwatch;
    timeunit 1ns;
    timeprecision 1ps;

    import kcs_pkg::*;

    localparam bit OPC_KEY        = 1'b0;
    localparam bit OPC_TICK       = 1'b1;
    localparam int RANDOM_ITEMS   = 540;
    localparam int TAIL_ITEMS     = 140;
    localparam int PAUSE_POINT    = 300;
    localparam int TAIL_TICKS     = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;

    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_s_tvalid = 1'b0;
    logic                        o_s_tready;
    logic [7:0]                  i_s_tdata  = '0;   // [3:0] key_code
    logic [0:0]                  i_s_tuser  = '0;   // [0] opcode (1 = tick)
    logic                        o_m_tvalid;
    logic                        i_m_tready = 1'b1;
    // [0] timer_mode, [2:1] calc_phase, [34:3] accumulator, [66:35] second_operand,
    // [68:67] operator_code, [100:69] shown_first_operand, [101] overflow,
    // [107:102] minutes, [113:108] seconds, [120:114] hundredths, [121] running,
    // [122] beep
    logic [OUT_BYTES*8-1:0]      o_m_tdata;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned words_checked;
    int unsigned overflows_seen;
    int unsigned beeps_seen;

    int unsigned items_sent  = 0;
    int unsigned keys_sent   = 0;
    int unsigned ticks_sent  = 0;
    int unsigned idle_cycles = 0;
    int unsigned ready_hold  = 0;
    bit          in_timer    = 1'b0;
    bit          gappy       = 1'b0;
    bit          quiet       = 1'b0;

    keypad_calculator_stopwatch DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    kcs_stream_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_tvalid      (i_s_tvalid),
        .i_in_tready      (o_s_tready),
        .i_in_tdata       (i_s_tdata),
        .i_in_tuser       (i_s_tuser),
        .i_out_tvalid     (o_m_tvalid),
        .i_out_tready     (i_m_tready),
        .i_out_tdata      (o_m_tdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_words_checked  (words_checked),
        .o_overflows_seen (overflows_seen),
        .o_beeps_seen     (beeps_seen)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stall the result channel in random bursts, with long open stretches
    always @(negedge i_clk) begin
        if (quiet) begin
            i_m_tready <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    i_m_tready <= 1'b0;
                    ready_hold <= $urandom_range(0, 10);
                end
                9: begin
                    i_m_tready <= 1'b1;
                    ready_hold <= $urandom_range(50, 200);
                end
                default: begin
                    i_m_tready <= 1'b1;
                    ready_hold <= $urandom_range(1, 15);
                end
            endcase
        end
    end

    // End the run when neither channel has moved a word for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Offer one word from a falling edge and hold it until accepted
    task automatic send_item(input bit opc, input logic [3:0] key);
        if (!quiet && gappy && $urandom_range(0, 5) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = opc;
        i_s_tdata  = {4'd0, key};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
        if (opc == OPC_TICK) begin
            ticks_sent++;
        end else begin
            keys_sent++;
            if (key == CODE_MODE)
                in_timer = !in_timer;
        end
    endtask

    task automatic press(input logic [3:0] key);
        send_item(OPC_KEY, key);
    endtask

    task automatic tick_run(input int count);
        repeat (count) send_item(OPC_TICK, 4'($urandom_range(0, 15)));
    endtask

    // Key in a decimal operand; long ones run into the entry limit
    task automatic key_in_operand();
        int len;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 5);
        repeat (len) press(4'($urandom_range(0, 9)));
    endtask

    function automatic logic [3:0] any_operator();
        return CODE_PLUS + 4'($urandom_range(0, 2));
    endfunction

    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic calc_session();
        if (in_timer)
            press(CODE_MODE);
        key_in_operand();
        press(any_operator());
        key_in_operand();
        press(CODE_ENTER);
        // chain onto the result, or start afresh from a digit
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 1) == 0) begin
                press(any_operator());
                key_in_operand();
                press(CODE_ENTER);
            end else begin
                key_in_operand();
            end
        end
        if ($urandom_range(0, 4) == 0)
            press(CODE_CLEAR);
    endtask

    task automatic timer_session(input int count);
        if (!in_timer)
            press(CODE_MODE);
        if ($urandom_range(0, 2) == 0)
            press(CODE_CLEAR);
        press(CODE_ENTER);
        tick_run(count);
        if ($urandom_range(0, 1) == 0) begin
            press(CODE_ENTER);
            tick_run($urandom_range(0, 5));
        end
        if ($urandom_range(0, 3) == 0)
            press(4'($urandom_range(0, 15)));
        if ($urandom_range(0, 2) == 0)
            press(CODE_MODE);
    endtask

    initial begin : stimulus
        bit paused;
        paused = 1'b0;

        // hold reset low at the start, then release it
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: enter ignored in the first phase, entry limit, overflow,
        // negative result, ignored operator, digit after a result, clear
        gappy = 1'b1;
        press(CODE_ENTER);
        repeat (10) press(4'd9);
        press(CODE_MUL);
        press(4'd3);
        press(CODE_ENTER);
        press(CODE_MINUS);
        press(4'd7);
        press(CODE_ENTER);
        press(CODE_PLUS);
        press(CODE_MUL);
        press(4'd0);
        press(CODE_ENTER);
        press(4'd5);
        press(CODE_CLEAR);
        // stopwatch: digits and operators ignored, start beeps, stop, reset, leave
        press(CODE_MODE);
        press(4'd4);
        press(CODE_MINUS);
        press(CODE_ENTER);
        send_item(OPC_TICK, CODE_ENTER);
        press(CODE_ENTER);
        press(CODE_CLEAR);
        press(CODE_MODE);

        // Random: mostly well-formed calculations and stopwatch runs, some noise
        while (items_sent < RANDOM_ITEMS) begin
            gappy = $urandom_range(0, 2) != 0;
            if (!paused && items_sent >= PAUSE_POINT) begin
                // let every result drain, then run past a second with idling
                wait_drained();
                paused = 1'b1;
                gappy  = 1'b1;
                timer_session($urandom_range(100, 130));
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: calc_session();
                6, 7: timer_session(($urandom_range(0, 3) == 0) ? $urandom_range(95, 120)
                                                                 : $urandom_range(1, 60));
                default: begin
                    repeat ($urandom_range(1, 8))
                        send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
                end
            endcase
        end

        // Last part without idling: more calculations, then a short stopwatch run
        quiet = 1'b1;
        while (items_sent < RANDOM_ITEMS + TAIL_ITEMS)
            calc_session();
        timer_session(TAIL_TICKS);

        i_s_tvalid = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d key presses and %0d ticks; %0d result words compared.",
                 keys_sent, ticks_sent, words_checked);
        $display("Saw %0d overflowing results and %0d beeps, with seconds carries covered.",
                 overflows_seen, beeps_seen);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
